// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the corner detector.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-implication property, sampled at the rising clock edge.
`define SCD_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies consequence in the next.
`define SCD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/scd_pkg.sv =====
// Shared constants and types of the saddle corner detector.
// No dependencies.
package scd_pkg;

	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;
	localparam int RADIUS = 2;
	localparam int WIN = 2 * RADIUS + 1;
	localparam int LINES = 2 * RADIUS;

	localparam int PIX_W = 16;
	localparam int DIM_W = 11;
	localparam int POS_W = 10;
	localparam int ADDR_W = $clog2(MAX_COLS);
	localparam int CNT_W = $clog2(MAX_ROWS * MAX_COLS + 1);
	localparam int LAG_W = $clog2(RADIUS * MAX_COLS + RADIUS + 1);
	localparam int WORD_W = LINES * PIX_W;
	localparam int OUT_TDATA_W = ((1 + 2 * POS_W + 7) / 8) * 8;

	localparam int ROWS_RESET = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;
	localparam int COLS_RESET = (MAX_COLS < 1024) ? MAX_COLS : 1024;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 2'd1;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic                     take;
		logic                     emit;
		logic                     border;
		logic                     last;
		logic [ADDR_W-1:0]        addr;
		logic [POS_W-1:0]         row;
		logic [POS_W-1:0]         col;
		logic signed [PIX_W-1:0]  pixel;
	} cmd_t;

endpackage

// ===== rtl/saddle_corner_detector_5x5.sv =====
// Top level of the saddle corner detector.
// Instantiates scd_front, scd_queue and scd_back. Uses scd_pkg.

// Takes one signed 16-bit pixel per clock in raster order while s_tready is high and
// returns one flag per pixel, one per clock while m_tready is high, the flag of a pixel
// leaving after the input has run 2*image_cols+2 items ahead; after the frame's last
// pixel, send drain items (or further pixels, which act as drains) until the flag with
// tlast has been taken. A released result passes the command queue, the s1 stage and
// the output register. The rate is set by the line store, a single memory of MAX_COLS
// words (image_cols in use) read and written once per pixel; the 4-entry command queue
// lets input keep flowing for a few items while the output is stalled. The line store
// needs no clearing pass after reset. Writes to a known register reset the frame counters.
module saddle_corner_detector_5x5 (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [scd_pkg::PIX_W-1:0]       s_tdata,   // [15:0] pixel
	input  logic                            s_tuser,   // [0] kind
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [scd_pkg::OUT_TDATA_W-1:0] m_tdata,   // [0] corner_flag, [10:1] out_row,
	                                                   // [20:11] out_col, [23:21] zero
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [scd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [scd_pkg::DIM_W-1:0]       cfg_data
);
	import scd_pkg::*;

	cmd_t push_cmd, pop_cmd;
	logic push, pop, full, empty;

	scd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full)
	);

	scd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (empty)
	);

	scd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (empty),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/scd_front.sv =====
// Front end: input and configuration handshakes, frame counters, border test.
// Emits one command per transfer that stores a pixel or releases a result. Uses scd_pkg.
module scd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [scd_pkg::PIX_W-1:0]     s_tdata,
	input  logic                          s_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [scd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [scd_pkg::DIM_W-1:0]     cfg_data,
	output logic                          push,
	output scd_pkg::cmd_t                 push_cmd,
	input  logic                          full
);
	import scd_pkg::*;

	logic [DIM_W-1:0] rows_q, cols_q, in_col_q, emit_row_q, emit_col_q;
	logic [CNT_W-1:0] total_q, recv_q, done_q, done_inc;
	logic [LAG_W-1:0] lag;
	logic [DIM_W-1:0] cfg_clamped;
	logic             accept, all_in, take, emit, frame_done, border, cfg_known;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
		logic [DIM_W-1:0] r;
		r = v;
		if (r == '0) r = DIM_W'(1);
		if (int'(r) > hi) r = DIM_W'(hi);
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	// register writes take priority, so input is held off while one is presented
	assign s_tready = !full && !cfg_valid;
	assign accept = s_tvalid && s_tready;
	assign cfg_known = (cfg_index == REG_IMAGE_ROWS) || (cfg_index == REG_IMAGE_COLS);
	assign cfg_clamped = clamp_dim(cfg_data,
		(cfg_index == REG_IMAGE_ROWS) ? MAX_ROWS : MAX_COLS);

	assign lag = LAG_W'(cols_q * RADIUS + RADIUS);
	assign all_in = recv_q >= total_q;
	assign take = !all_in && (s_tuser == KIND_PIXEL);
	assign emit = all_in ? (done_q < total_q)
		: (take && (({1'b0, done_q} + (CNT_W+1)'(lag)) <= {1'b0, recv_q}));
	assign done_inc = done_q + CNT_W'(1);
	assign frame_done = done_inc >= total_q;
	assign border = (emit_row_q < DIM_W'(RADIUS)) || (emit_col_q < DIM_W'(RADIUS))
		|| ((DIM_W+1)'(emit_row_q) + (DIM_W+1)'(RADIUS) >= (DIM_W+1)'(rows_q))
		|| ((DIM_W+1)'(emit_col_q) + (DIM_W+1)'(RADIUS) >= (DIM_W+1)'(cols_q));

	assign push = accept && (take || emit);
	always_comb begin
		push_cmd.take = take;
		push_cmd.emit = emit;
		push_cmd.border = border;
		push_cmd.last = (done_inc == total_q);
		push_cmd.addr = ADDR_W'(in_col_q);
		push_cmd.row = POS_W'(emit_row_q);
		push_cmd.col = POS_W'(emit_col_q);
		push_cmd.pixel = s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_W'(ROWS_RESET);
			cols_q <= DIM_W'(COLS_RESET);
			total_q <= CNT_W'(ROWS_RESET * COLS_RESET);
			recv_q <= '0;
			done_q <= '0;
			in_col_q <= '0;
			emit_row_q <= '0;
			emit_col_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_known) begin
				if (cfg_index == REG_IMAGE_ROWS) begin
					rows_q <= cfg_clamped;
					total_q <= CNT_W'(cfg_clamped) * CNT_W'(cols_q);
				end else begin
					cols_q <= cfg_clamped;
					total_q <= CNT_W'(rows_q) * CNT_W'(cfg_clamped);
				end
				recv_q <= '0;
				done_q <= '0;
				in_col_q <= '0;
				emit_row_q <= '0;
				emit_col_q <= '0;
			end
		end else if (accept) begin
			if (take) begin
				recv_q <= recv_q + CNT_W'(1);
				if (in_col_q + DIM_W'(1) >= cols_q) in_col_q <= '0;
				else in_col_q <= in_col_q + DIM_W'(1);
			end
			if (emit) begin
				if (frame_done) begin
					recv_q <= '0;
					done_q <= '0;
					in_col_q <= '0;
					emit_row_q <= '0;
					emit_col_q <= '0;
				end else begin
					done_q <= done_inc;
					if (emit_col_q + DIM_W'(1) >= cols_q) begin
						emit_col_q <= '0;
						emit_row_q <= emit_row_q + DIM_W'(1);
					end else begin
						emit_col_q <= emit_col_q + DIM_W'(1);
					end
				end
			end
		end
	end

endmodule

// ===== rtl/scd_queue.sv =====
// Command queue between the front end and the pixel pipeline.
// Small register FIFO, power-of-two depth. Uses scd_pkg.
module scd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  scd_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output scd_pkg::cmd_t pop_cmd,
	output logic          empty
);
	import scd_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop) count_q <= count_q + (PTR_W+1)'(1);
			else if (pop && !push) count_q <= count_q - (PTR_W+1)'(1);
		end
	end

endmodule

// ===== rtl/scd_back.sv =====
// Back end: line store, 5x5 window, saddle test and output register.
// Consumes commands from scd_queue. Uses scd_pkg.
module scd_back (
	input  logic                            clk,
	input  logic                            arst_n,
	output logic                            pop,
	input  scd_pkg::cmd_t                   pop_cmd,
	input  logic                            empty,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [scd_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                            m_tlast
);
	import scd_pkg::*;

	// each word holds one column of the last LINES rows, oldest in the low bits
	logic [WORD_W-1:0]       line_mem [MAX_COLS];
	logic [WORD_W-1:0]       word_s1, new_word;
	cmd_t                    cmd_s1;
	logic                    valid_s1, en, fwd, saddle;
	logic signed [PIX_W-1:0] win_q [WIN][WIN];
	logic signed [PIX_W-1:0] nw [WIN][WIN];
	logic signed [PIX_W-1:0] x, pa [4], pb [4], mn [4], mx [4];
	logic                    out_valid_q, flag_q, last_q;
	logic [POS_W-1:0]        row_q, col_q;

	assign en = !out_valid_q || m_tready;
	assign pop = en && !empty;
	assign new_word = {cmd_s1.pixel, word_s1[WORD_W-1:PIX_W]};
	assign fwd = valid_s1 && cmd_s1.take && (cmd_s1.addr == pop_cmd.addr);

	always_ff @(posedge clk) begin
		if (en) begin
			if (valid_s1 && cmd_s1.take) line_mem[cmd_s1.addr] <= new_word;
			word_s1 <= fwd ? new_word : line_mem[pop_cmd.addr];
		end
	end

	always_comb begin
		for (int i = 0; i < WIN; i++) begin
			for (int j = 0; j < WIN - 1; j++) nw[i][j] = win_q[i][j+1];
		end
		for (int i = 0; i < LINES; i++) nw[i][WIN-1] = word_s1[i*PIX_W +: PIX_W];
		nw[WIN-1][WIN-1] = cmd_s1.pixel;
	end

	always_comb begin
		x = nw[RADIUS][RADIUS];
		pa[0] = nw[2*RADIUS][RADIUS];
		pb[0] = nw[0][RADIUS];
		pa[1] = nw[RADIUS][2*RADIUS];
		pb[1] = nw[RADIUS][0];
		pa[2] = nw[2*RADIUS][2*RADIUS];
		pb[2] = nw[0][0];
		pa[3] = nw[2*RADIUS][0];
		pb[3] = nw[0][2*RADIUS];
		for (int k = 0; k < 4; k++) begin
			mn[k] = (pa[k] < pb[k]) ? pa[k] : pb[k];
			mx[k] = (pa[k] < pb[k]) ? pb[k] : pa[k];
		end
		saddle = (mx[1] < x && x < mn[0]) || (mx[0] < x && x < mn[1])
			|| (mx[2] < x && x < mn[3]) || (mx[3] < x && x < mn[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= pop_cmd;
			if (valid_s1 && cmd_s1.take) win_q <= nw;
			flag_q <= cmd_s1.border || saddle;
			row_q <= cmd_s1.row;
			col_q <= cmd_s1.col;
			last_q <= cmd_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1 <= pop;
			out_valid_q <= valid_s1 && cmd_s1.emit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {(OUT_TDATA_W - 1 - 2 * POS_W)'(0), col_q, row_q, flag_q};
	assign m_tlast = last_q;

endmodule

// ===== rtl/scd_checker.sv =====
// Port-level checks of the corner detector, bound to the top level.
// Uses scd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [scd_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                            m_tlast,
	input logic                            cfg_valid
);
	import scd_pkg::*;

	`SCD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
	`SCD_ASSERT(a_last_flag, clk, arst_n, m_tvalid && m_tlast |-> m_tdata[0], "final pixel not flagged")
	`SCD_ASSERT(a_edge_flag, clk, arst_n, m_tvalid && (m_tdata[POS_W:1] < POS_W'(RADIUS) || m_tdata[2*POS_W:POS_W+1] < POS_W'(RADIUS)) |-> m_tdata[0], "top or left border pixel not flagged")
	`SCD_ASSERT(a_pad_zero, clk, arst_n, m_tvalid |-> m_tdata[OUT_TDATA_W-1:2*POS_W+1] == '0, "tdata padding not zero")
	`SCD_ASSERT(a_cfg_blocks_in, clk, arst_n, cfg_valid |-> !s_tready, "input ready during write")

endmodule

bind saddle_corner_detector_5x5 scd_checker u_scd_checker (.*);
